### sv/xsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xsr_pkg: constants for the ranged xorshift128 generator
// Generator seeds, marker, shift amounts and range-reduction constants.
// ----------------------------------------------------------------------------
package xsr_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned SPAN_W  = 23;   // limit * 100 < 2^23
	localparam int unsigned CNT_W   = 5;    // one quotient bit per cycle over WORD_W

	localparam logic [WORD_W-1:0] MARKER = 32'h1234_5678;
	localparam logic [WORD_W-1:0] Y_INIT = 32'd362436069;
	localparam logic [WORD_W-1:0] Z_INIT = 32'd521288629;
	localparam logic [WORD_W-1:0] W_INIT = 32'd88675123;

	localparam int unsigned SH_A = 11;
	localparam int unsigned SH_B = 19;
	localparam int unsigned SH_C = 8;

	localparam logic [SPAN_W-1:0] SCALE = 23'd100;

	// floor(r / 100) == (r * RECIP) >> RECIP_SH, exact for r < 2^23
	localparam int unsigned RECIP_W  = 24;
	localparam int unsigned RECIP_SH = 30;
	localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
	localparam int unsigned PROD_W = SPAN_W + RECIP_W;

endpackage : xsr_pkg
`default_nettype wire

### sv/xorshift128_ranged_random_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xorshift128_ranged_random_top: xorshift128 generator with range reduction
// Steps the generator once per request; value below limit, or error if limit is 0.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests: in_valid / in_stall with range_limit; in_stall is high while a
//    request is being worked on. Results: out_valid / out_stall with
//    random_value and range_error, one per request, held while out_stall is high.
//  - Seed: cfg_write_en / cfg_write_data; used in place of the first generator
//    word at the next step whenever that word holds the marker. Write only while idle.
//  - Sequence: the accepting edge steps the generator, then a bit-serial
//    restoring divide (w mod limit*100), one reciprocal multiply for the
//    divide by 100 and one result load from the hold state; a new request
//    is taken only once the block is back in idle. A zero limit skips the
//    divider and goes from the accepting edge straight to the hold state.
//  - Stall: one finished request can wait in the hold state behind a stalled
//    result; a further request is then held off until the result is taken.
//  - Reset: generator words and seed register return to their reset values;
//    both channels go idle.
// ----------------------------------------------------------------------------
module xorshift128_ranged_random_top
	import xsr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// seed register
	input  wire logic                cfg_write_en,
	input  wire logic [WORD_W-1:0]   cfg_write_data,
	// request channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [LIMIT_W-1:0]  range_limit,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [LIMIT_W-1:0]       random_value,
	output logic                     range_error
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCALE,
		ST_HOLD
	} state_t;

	state_t              state_q;
	logic [WORD_W-1:0]   seed_q;
	logic [WORD_W-1:0]   x_q, y_q, z_q, w_q;
	logic [WORD_W-1:0]   dvd_q;      // dividend, shifted out msb first
	logic [SPAN_W-1:0]   span_q;     // limit * 100
	logic [SPAN_W-1:0]   rem_q;      // running remainder, below span_q throughout the divide
	logic [CNT_W-1:0]    cnt_q;
	logic                err_q;
	logic [PROD_W-1:0]   prod_q;

	logic                req_take;
	logic                out_free;
	logic [WORD_W-1:0]   x_eff, t_val, w_next;
	logic [SPAN_W-1:0]   span_next;
	logic [SPAN_W:0]     rem_sh, rem_diff;
	logic [SPAN_W-1:0]   rem_next;

	assign in_stall = (state_q != ST_IDLE);
	assign req_take = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// generator step; marker in x means the seed stands in for x
	always_comb begin
		x_eff  = (x_q == MARKER) ? seed_q : x_q;
		t_val  = x_eff ^ (x_eff << SH_A);
		w_next = (w_q ^ (w_q >> SH_B)) ^ (t_val ^ (t_val >> SH_C));
	end

	assign span_next = SPAN_W'({{(SPAN_W-LIMIT_W){1'b0}}, range_limit} * SCALE);

	// restoring division, one bit per cycle
	always_comb begin
		rem_sh   = {rem_q, dvd_q[WORD_W-1]};
		rem_diff = rem_sh - {1'b0, span_q};
		rem_next = (rem_sh >= {1'b0, span_q}) ? rem_diff[SPAN_W-1:0] : rem_sh[SPAN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seed_q       <= MARKER;
			x_q          <= MARKER;
			y_q          <= Y_INIT;
			z_q          <= Z_INIT;
			w_q          <= W_INIT;
			dvd_q        <= '0;
			span_q       <= '0;
			rem_q        <= '0;
			cnt_q        <= '0;
			err_q        <= 1'b0;
			prod_q       <= '0;
			out_valid    <= 1'b0;
			random_value <= '0;
			range_error  <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				seed_q <= cfg_write_data;
			end
			// hold state reloads the result register itself
			if (out_valid && !out_stall && (state_q != ST_HOLD)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						x_q    <= y_q;
						y_q    <= z_q;
						z_q    <= w_q;
						w_q    <= w_next;
						dvd_q  <= w_next;
						span_q <= span_next;
						rem_q  <= '0;
						cnt_q  <= CNT_W'(WORD_W - 1);
						err_q  <= (range_limit == '0);
						state_q <= (range_limit == '0) ? ST_HOLD : ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_next;
					dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					prod_q  <= PROD_W'({{RECIP_W{1'b0}}, rem_q} * {{SPAN_W{1'b0}}, RECIP});
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						range_error  <= err_q;
						random_value <= err_q ? '0 : prod_q[RECIP_SH +: LIMIT_W];
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// remainder stays reduced throughout the divide
	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < span_q))
		else $error("remainder not below span");

	// a zero limit bypasses the divider
	a_zero_skips_div: assert property (@(posedge clk) disable iff (!arst_n)
		(req_take && (range_limit == '0)) |=> (state_q == ST_HOLD))
		else $error("zero limit entered divider");

	// last divide cycle hands over to the scale step
	a_div_to_scale: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV) && (cnt_q == '0)) |=> (state_q == ST_SCALE))
		else $error("divider did not finish after last bit");

	// flagged results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (random_value == '0))
		else $error("range error with nonzero value");
`endif

endmodule : xorshift128_ranged_random_top
`default_nettype wire

### bench/xsr_draw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_draw_checker: result predictor and comparator for the ranged generator
// Tracks the seed register and its own copy of the four xorshift128 words,
// queues the expected draw for every accepted request, and compares each
// accepted result against the oldest one.
// ----------------------------------------------------------------------------
module xsr_draw_checker
	import xsr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write_en,
	input  wire logic [WORD_W-1:0]   cfg_write_data,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic [LIMIT_W-1:0]  range_limit,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire logic [LIMIT_W-1:0]  random_value,
	input  wire logic                range_error,
	output int                       error_count,
	output int                       pending_count
);

	localparam logic [31:0] GEN_MARKER = 32'h1234_5678;
	localparam logic [31:0] GEN_Y0     = 32'd362436069;
	localparam logic [31:0] GEN_Z0     = 32'd521288629;
	localparam logic [31:0] GEN_W0     = 32'd88675123;
	localparam int          MAX_REPORTS = 10;

	typedef struct packed {
		logic [LIMIT_W-1:0] value;
		logic               flag;
	} draw_t;

	logic [31:0] seed_copy;
	logic [31:0] gen_x, gen_y, gen_z, gen_w;
	draw_t       expected_draws[$];
	draw_t       want, got;

	// one generator step, then reduce w into [0, lim); a zero lim sets the flag
	function automatic draw_t next_draw(input logic [LIMIT_W-1:0] lim);
		logic [31:0] t;
		logic [31:0] span;
		logic [31:0] reduced;
		draw_t       d;
		if (gen_x == GEN_MARKER)
			gen_x = seed_copy;
		t = gen_x ^ (gen_x << 11);
		gen_x = gen_y;
		gen_y = gen_z;
		gen_z = gen_w;
		gen_w = (gen_w ^ (gen_w >> 19)) ^ (t ^ (t >> 8));
		d.value = '0;
		d.flag  = 1'b0;
		if (lim == '0) begin
			d.flag = 1'b1;
		end else begin
			span    = lim;
			span    = span * 32'd100;
			reduced = (gen_w % span) / 32'd100;
			d.value = reduced[LIMIT_W-1:0];
		end
		return d;
	endfunction

	task automatic note_failure(input string what, input draw_t w, input draw_t g);
		if (error_count < MAX_REPORTS)
			$display("%0t ns: %s: expected value %0d error %0b, got value %0d error %0b",
				$time, what, w.value, w.flag, g.value, g.flag);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_copy = GEN_MARKER;
			gen_x     = GEN_MARKER;
			gen_y     = GEN_Y0;
			gen_z     = GEN_Z0;
			gen_w     = GEN_W0;
			expected_draws.delete();
			error_count   = 0;
			pending_count = 0;
		end else begin
			if (cfg_write_en)
				seed_copy = cfg_write_data;
			if (out_valid && !out_stall) begin
				got.value = random_value;
				got.flag  = range_error;
				if (expected_draws.size() == 0) begin
					note_failure("result with no request outstanding", '0, got);
				end else begin
					want = expected_draws.pop_front();
					if (got !== want)
						note_failure("draw mismatch", want, got);
				end
			end
			if (in_valid && !in_stall)
				expected_draws.push_back(next_draw(range_limit));
			pending_count = expected_draws.size();
		end
	end

endmodule : xsr_draw_checker

### bench/xorshift128_ranged_random_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift128_ranged_random_top_tb: bench for the ranged xorshift128 generator
// Drives range-limit requests through the valid/stall channels under several
// idle and stall mixes, writes the seed register between phases, and lets
// the draw checker compare every result against its own generator copy.
// ----------------------------------------------------------------------------
module xorshift128_ranged_random_top_tb;
	import xsr_pkg::*;

	localparam logic [31:0] SEED_MARKER   = 32'h1234_5678;
	localparam int          PHASE_ITEMS   = 220;
	localparam int          SQUEEZE_ITEMS = 70;
	localparam int          HOLD_CYCLES   = 400;  // well over two full draws
	localparam int          SETTLE_CYCLES = 4;
	localparam int          DRAIN_CYCLES  = 40;   // a bit over one draw latency
	localparam int          TIMEOUT_NS    = 10_000_000;

	logic                clk;
	logic                arst_n         = 1'b0;
	logic                cfg_write_en   = 1'b0;
	logic [WORD_W-1:0]   cfg_write_data = '0;
	logic                in_valid       = 1'b0;
	logic [LIMIT_W-1:0]  range_limit    = '0;
	logic                out_stall      = 1'b0;
	wire logic           in_stall;
	wire logic           out_valid;
	wire logic [LIMIT_W-1:0] random_value;
	wire logic           range_error;

	int error_count;
	int pending_count;

	// traffic shaping, percent of cycles
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_req      = 1'b0;
	int hold_left     = 0;

	// limits chosen for the directed opener: zero, the small end, the
	// power-of-two boundaries, alternating bit patterns and the top of the range
	logic [LIMIT_W-1:0] opener_limits [16] = '{
		16'd0, 16'd1, 16'd2, 16'd3, 16'd100, 16'd255, 16'd256, 16'd1000,
		16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF, 16'd0, 16'd1
	};

	xorshift128_ranged_random_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.range_limit    (range_limit),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.random_value   (random_value),
		.range_error    (range_error)
	);

	// Watches both channels and the seed port; hands back the running
	// failure count and how many draws are still owed.
	xsr_draw_checker draw_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.range_limit    (range_limit),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.random_value   (random_value),
		.range_error    (range_error),
		.error_count    (error_count),
		.pending_count  (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side. A hold-off request from the main flow turns into a long
	// unbroken stall counted here; otherwise stall at the current rate.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Mostly small or structured limits so the reduction edges get hit often,
	// with a share of fully random 16-bit values so every bit toggles.
	function automatic logic [LIMIT_W-1:0] pick_limit();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return LIMIT_W'($urandom_range(1, 4));
			2:       return '1;
			3:       return 16'd1 << $urandom_range(0, 15);
			4, 5:    return LIMIT_W'($urandom_range(1, 200));
			default: return r[LIMIT_W-1:0];
		endcase
	endfunction

	// Offer one request after a random idle gap, hold it until taken.
	// Returns on the edge that accepted it, with in_valid still high.
	task automatic send_request(input logic [LIMIT_W-1:0] lim);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		range_limit <= lim;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop offering, let every owed draw come back, then write the seed.
	// The first poll comes after the next edge, so the checker has logged the
	// last accepted request before pending_count is read.
	task automatic settle_and_seed(input logic [WORD_W-1:0] seed);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= seed;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_rate, input int count);
		send_idle_pct = idle_pct;
		stall_pct     = stall_rate;
		repeat (count) send_request(pick_limit());
	endtask

	initial begin
		logic [WORD_W-1:0] first_seed;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The seed only matters while word x holds the marker, i.e. for the
		// very first request after reset. Write the marker explicitly, then
		// pick what the first request really loads: sometimes the marker
		// itself (then stepped like any other x value), sometimes the extremes.
		settle_and_seed(SEED_MARKER);
		case ($urandom_range(0, 4))
			0:       first_seed = SEED_MARKER;
			1:       first_seed = '0;
			2:       first_seed = '1;
			default: first_seed = $urandom;
		endcase
		settle_and_seed(first_seed);

		// directed opener, no idling on either side
		send_idle_pct = 0;
		stall_pct     = 0;
		foreach (opener_limits[i])
			send_request(opener_limits[i]);

		// random phases; the seed is rewritten between them while idle
		settle_and_seed('0);
		run_phase(0, 0, PHASE_ITEMS);
		settle_and_seed('1);
		run_phase(62, 0, PHASE_ITEMS);
		settle_and_seed(SEED_MARKER);
		run_phase(0, 62, PHASE_ITEMS);
		settle_and_seed($urandom);
		run_phase(23, 23, PHASE_ITEMS);

		// back-pressure: receiver holds off for a long stretch while the
		// sender keeps offering, so the result and hold stages fill and the
		// request side stalls
		settle_and_seed($urandom);
		hold_req = 1'b1;
		run_phase(0, 0, SQUEEZE_ITEMS);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// hang guard
	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule : xorshift128_ranged_random_top_tb
